// File: hw/rtl/dfmod_pkg.sv
// ----------------------------------------------------------------------------
// dfmod_pkg: shared types and constants for the binary64 remainder block
// Holds the sequencer state type and the format constants.
// ----------------------------------------------------------------------------
package dfmod_pkg;

  localparam int unsigned ExpW  = 11;
  localparam int unsigned FracW = 52;
  localparam int unsigned SigW  = 53;

  localparam logic [ExpW-1:0]  ExpMax    = 11'h7ff;
  localparam logic [63:0]      CanonNan  = 64'h7ff8000000000000;
  localparam logic [63:0]      QuietBit  = 64'h0008000000000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM_X,
    ST_NORM_Y,
    ST_REDUCE,
    ST_RENORM,
    ST_PACK
  } state_t;

endpackage

// File: hw/rtl/double_fmod_remainder.sv
// ----------------------------------------------------------------------------
// double_fmod_remainder: exact IEEE-754 binary64 fmod
// Iterative shift-subtract remainder with a small sequencer.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to present a request; one result appears on
// out_remainder_bits for a single cycle with out_valid high and must be taken
// then, since the receiver cannot stall the block. Special cases keep busy high
// through ST_PACK and while out_valid is high. Otherwise a request steps through
// ST_NORM_X and ST_NORM_Y (normalize shifts of x and y), ST_REDUCE (one step
// per unit of exponent difference), ST_RENORM (renormalize shifts) and ST_PACK;
// the reduction uses one 54-bit compare-subtract unit that handles one quotient
// bit per cycle, plus the same shifter used for normalizing.
module double_fmod_remainder
  import dfmod_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_dividend_bits,
  input  logic [63:0] in_divisor_bits,
  output logic        out_valid,
  output logic [63:0] out_remainder_bits
);

  state_t state_r, state_nxt;
  logic [SigW:0]     r_r, r_nxt;     // 54 bits: shifted remainder
  logic [SigW-1:0]   my_r, my_nxt;
  logic signed [12:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic              sign_r, sign_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       res_r, res_nxt;

  logic              x_nan, y_nan, x_inf, y_zero, y_inf, ax_lt, ax_eq;
  logic [10:0]       exi, eyi;
  logic [SigW:0]     sub;
  logic              ge;
  logic signed [12:0] sh;
  logic [SigW:0]     den;
  logic              accept;

  // A request is taken only while the block is idle and no result is showing.
  assign accept = start && !busy;

  assign exi    = in_dividend_bits[62:52];
  assign eyi    = in_divisor_bits[62:52];
  assign x_nan  = (exi == ExpMax) && (in_dividend_bits[51:0] != '0);
  assign y_nan  = (eyi == ExpMax) && (in_divisor_bits[51:0] != '0);
  assign x_inf  = (exi == ExpMax);
  assign y_zero = (in_divisor_bits[62:0] == '0);
  assign y_inf  = (eyi == ExpMax);
  assign ax_lt  = in_dividend_bits[62:0] < in_divisor_bits[62:0];
  assign ax_eq  = in_dividend_bits[62:0] == in_divisor_bits[62:0];

  // The shared compare-subtract unit.
  assign den = {1'b0, my_r};
  assign ge  = (r_r >= den);
  assign sub = r_r - den;
  assign sh  = 13'sd1 - ey_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (x_nan || y_nan || x_inf || y_zero || y_inf || ax_lt || ax_eq) begin
            state_nxt = ST_PACK;
          end else begin
            state_nxt = ST_NORM_X;
          end
        end
      end
      ST_NORM_X: if (r_r[FracW]) state_nxt = ST_NORM_Y;
      ST_NORM_Y: if (my_r[FracW]) state_nxt = ST_REDUCE;
      ST_REDUCE: if (ex_r == ey_r) state_nxt = ST_RENORM;
      ST_RENORM: if (r_r == '0 || r_r[FracW]) state_nxt = ST_PACK;
      ST_PACK:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    r_nxt = r_r; my_nxt = my_r; ex_nxt = ex_r; ey_nxt = ey_r;
    sign_nxt = sign_r; res_nxt = res_r; out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sign_nxt = in_dividend_bits[63];
          r_nxt  = {2'b00, in_dividend_bits[51:0]};
          my_nxt = {1'b0, in_divisor_bits[51:0]};
          ex_nxt = (exi == '0) ? 13'sd1 : $signed({2'b00, exi});
          ey_nxt = (eyi == '0) ? 13'sd1 : $signed({2'b00, eyi});
          if (exi != '0) r_nxt[FracW] = 1'b1;
          if (eyi != '0) my_nxt[FracW] = 1'b1;
          if (x_nan)              res_nxt = in_dividend_bits | QuietBit;
          else if (y_nan)         res_nxt = in_divisor_bits | QuietBit;
          else if (x_inf || y_zero) res_nxt = CanonNan;
          else if (y_inf || ax_lt)  res_nxt = in_dividend_bits;
          else if (ax_eq)           res_nxt = {in_dividend_bits[63], 63'd0};
        end
      end
      ST_NORM_X: begin
        if (!r_r[FracW]) begin
          r_nxt = r_r << 1;
          ex_nxt = ex_r - 13'sd1;
        end
      end
      ST_NORM_Y: begin
        if (!my_r[FracW]) begin
          my_nxt = my_r << 1;
          ey_nxt = ey_r - 13'sd1;
        end
      end
      ST_REDUCE: begin
        // Subtract, then shift in the next quotient bit unless finished.
        if (ex_r == ey_r) begin
          r_nxt = ge ? sub : r_r;
        end else begin
          r_nxt = (ge ? sub : r_r) << 1;
          ex_nxt = ex_r - 13'sd1;
        end
      end
      ST_RENORM: begin
        if (r_r != '0 && !r_r[FracW]) begin
          r_nxt = r_r << 1;
          ey_nxt = ey_r - 13'sd1;
        end
      end
      ST_PACK: begin
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  logic [63:0] packed_res;
  logic [SigW:0] sub_shift;
  always_comb begin
    sub_shift = r_r >> sh[5:0];
    if (r_r == '0) begin
      packed_res = {sign_r, 63'd0};
    end else if (ey_r <= 13'sd0) begin
      packed_res = (sh >= 13'sd64) ? {sign_r, 63'd0} : {sign_r, 9'd0, sub_shift};
    end else begin
      packed_res = {sign_r, ey_r[10:0], r_r[FracW-1:0]};
    end
  end

  logic arith_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      arith_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_IDLE && accept) arith_r <= (state_nxt == ST_NORM_X);
    end
    r_r    <= r_nxt;
    my_r   <= my_nxt;
    ex_r   <= ex_nxt;
    ey_r   <= ey_nxt;
    sign_r <= sign_nxt;
    if (state_r == ST_PACK && arith_r) res_r <= packed_res;
    else res_r <= res_nxt;
  end

  assign busy               = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_remainder_bits = res_r;

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PACK |=> out_valid_r) else $error("missing result");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_PACK) else $error("stray result");
  a_reduce_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REDUCE |-> ex_r >= ey_r) else $error("exponent underrun");
`endif

endmodule
